// File: sv/twlcd_pkg.sv
package twlcd_pkg;

  localparam int unsigned NibbleSteps  = 13;
  localparam int unsigned RequestSteps = 26;
  localparam int unsigned CountWidth   = 5;

  typedef logic [RequestSteps-1:0] frame_t;
  typedef logic [CountWidth-1:0]   count_t;

  // Actions
  localparam logic ACT_PUT_CHAR = 1'b0;
  localparam logic ACT_GOTO     = 1'b1;

  // Control characters with special handling
  localparam logic [7:0] CH_FORM_FEED = 8'h0C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // LCD command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_LINE_TWO   = 8'hC0;
  localparam logic [7:0] CMD_CURSOR_LFT = 8'h10;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [6:0] LINE_TWO_BASE  = 7'h40;

  // Remaining-step counts: the two at which the enable pulse is issued, and the full count.
  localparam count_t CNT_HIGH_ENABLE = count_t'(NibbleSteps + 1);
  localparam count_t CNT_LOW_ENABLE  = count_t'(1);
  localparam count_t CNT_FULL        = count_t'(RequestSteps);

  // One nibble on the wire: six zeros, a one, rs, four data bits MSB first,
  // then the enable pulse, which drives the data line high.
  function automatic logic [NibbleSteps-1:0] nibble_frame(input logic rs,
                                                          input logic [3:0] nib);
    nibble_frame = {6'b000000, 1'b1, rs, nib, 1'b1};
  endfunction

  function automatic frame_t build_frame(input logic       action,
                                         input logic [7:0] character,
                                         input logic [5:0] column,
                                         input logic [1:0] row);
    logic [6:0] base;
    logic [6:0] addr;
    logic [7:0] byte_out;
    logic       rs;
    base = (row != 2'd1) ? LINE_TWO_BASE : 7'h00;
    addr = base + {1'b0, column} - 7'd1;
    rs   = 1'b0;
    if (action == ACT_GOTO) begin
      byte_out = CMD_SET_DDRAM | {1'b0, addr};
    end else if (character == CH_FORM_FEED) begin
      byte_out = CMD_CLEAR;
    end else if (character == CH_NEWLINE) begin
      byte_out = CMD_LINE_TWO;
    end else if (character == CH_BACKSPACE) begin
      byte_out = CMD_CURSOR_LFT;
    end else begin
      byte_out = character;
      rs       = 1'b1;
    end
    build_frame = {nibble_frame(rs, byte_out[7:4]), nibble_frame(rs, byte_out[3:0])};
  endfunction

endpackage

// File: sv/two_wire_lcd_serializer_unit.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------
// request  | in_valid / in_ready       | action, character, column, row
// pin step | out_valid / out_ready     | data_level, strobe_kind, last_step
//
// Every request yields 26 pin-step transfers, one per cycle while out_ready is
// high; the 26-step frame shift register sets that figure. A request is
// decoded into its frame on transfer and held in a pending register, so the
// next request is taken while the current frame is still shifting out and
// frames follow with no gap. rst is synchronous and active high; it empties
// both the pending register and the shift register. A stall on out_ready
// freezes the current step.
module two_wire_lcd_serializer_unit
  import twlcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] character,
  input  logic [5:0] column,
  input  logic [1:0] row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       data_level,
  output logic       strobe_kind,
  output logic       last_step
);

  // Pending frame, decoded from the request at its transfer.
  frame_t pend_frame;
  logic   pend_valid;

  // Frame being shifted out; step one sits in the top bit.
  frame_t frame_shift;
  count_t step_count;
  logic   busy;

  logic   load;
  logic   in_fire;

  // The shift register takes the pending frame when it is empty or when its
  // final step is being transferred in this cycle.
  assign load    = pend_valid && (!busy || (out_ready && step_count == CNT_LOW_ENABLE));
  assign in_ready = !pend_valid || load;
  assign in_fire = in_valid && in_ready;

  assign out_valid   = busy;
  assign data_level  = frame_shift[RequestSteps-1];
  assign strobe_kind = (step_count == CNT_HIGH_ENABLE) || (step_count == CNT_LOW_ENABLE);
  assign last_step   = (step_count == CNT_LOW_ENABLE);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_frame <= build_frame(action, character, column, row);
    end
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      step_count  <= '0;
      busy        <= 1'b0;
    end else if (load) begin
      frame_shift <= pend_frame;
      step_count  <= CNT_FULL;
      busy        <= 1'b1;
    end else if (busy && out_ready) begin
      frame_shift <= {frame_shift[RequestSteps-2:0], 1'b0};
      step_count  <= step_count - count_t'(1);
      busy        <= (step_count != CNT_LOW_ENABLE);
    end
  end

`ifndef SYNTHESIS
  // The closing step of every request is an enable pulse.
  a_last_is_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_step |-> strobe_kind)
    else $error("last step is not an enable pulse");

  // While a frame is shifting, the count stays within one request.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step_count != '0) && (step_count <= CNT_FULL))
    else $error("step count out of range while busy");

  // An idle shifter holds no remaining steps.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step_count == '0)
    else $error("step count non-zero while idle");

  // A load always starts a full frame on the next cycle.
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && (step_count == CNT_FULL))
    else $error("load did not start a full frame");

  // Enable steps drive the data line high.
  a_enable_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && strobe_kind |-> data_level)
    else $error("enable step with data line low");
`endif

endmodule
